[rtl/lass_pkg.sv]
// Shared types and constants for the line-aligned stream splitter.
// Holds register indexes, opcodes and the control/status structs.
// No dependencies.
package lass_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PIECE_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PIECES  = 1'b1;

	localparam int PIECE_BYTES_W = 32;
	localparam int MAX_PIECES_W  = 7;

	localparam logic [PIECE_BYTES_W-1:0] PIECE_BYTES_RST = 32'd4194304;
	localparam logic [MAX_PIECES_W-1:0]  MAX_PIECES_RST  = 7'd64;

	// Input item kind
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	localparam logic [7:0] NEWLINE = 8'h0A;

	localparam int PIECE_NUM_W = 6;

	// Controller to datapath
	typedef struct packed {
		logic start;      // load a new file
		logic byte_in;    // count one file byte
		logic cnt_step;   // piece count search step
		logic div_step;   // one quotient bit of step = size / n
		logic arm;        // open target 1
		logic pend;       // close the pending piece at the byte counter
		logic skip_step;  // advance one target
		logic final_pc;   // give the final piece
	} lass_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic busy;
		logic hit;
		logic eof;
		logic trivial;
		logic cnt_done;
		logic n_one;
		logic div_done;
		logic skip_more;
		logic finish;
		logic pend_need;
		logic slot_free;
	} lass_sts_t;

endpackage

[rtl/line_aligned_stream_splitter.sv]
// A byte that settles no target and is not the last byte leaves the controller idle, ready
// for the next byte. A newline that settles targets goes to pend, then skips each target
// passed; pend and final wait for a free output slot. The last byte adds pend and final.
// A start item runs count search up to the piece limit, bit-serial division and arm, or
// goes to final for a one-piece file. A formed piece shows on m_tdata in the next cycle.
// Reset (arst_n low) clears control and config registers at once; no clearing pass.
module line_aligned_stream_splitter import lass_pkg::*; #(
	parameter int MAX_PIECES  = 64,
	parameter int OFFSET_BITS = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]             cfg_wdata,
	// Input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic                              s_tuser,   // op
	input  logic [((OFFSET_BITS+15)/8)*8-1:0] s_tdata,   // file_size, data_byte
	// Output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((2*OFFSET_BITS+13)/8)*8-1:0] m_tdata, // piece_offset, piece_length,
	                                                     // piece_number
	output logic                              m_tlast    // last_piece
);

	localparam int M_W = ((2*OFFSET_BITS + 13) / 8) * 8;

	lass_cmd_t               cmd;
	lass_sts_t               sts;
	logic [OFFSET_BITS-1:0]  file_size;
	logic [7:0]              data_byte;
	logic [OFFSET_BITS-1:0]  piece_offset;
	logic [OFFSET_BITS-1:0]  piece_length;
	logic [PIECE_NUM_W-1:0]  piece_number;

	// Unpack the input transaction: file size in the low bits, byte above it
	assign file_size = s_tdata[OFFSET_BITS-1:0];
	assign data_byte = s_tdata[OFFSET_BITS+7:OFFSET_BITS];

	// Controller: takes an item only when idle, then steps the datapath
	// through count search, division, target skips and piece output.
	lass_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: holds file state and a one-entry output register, so the
	// next item can be taken while a finished piece still waits downstream.
	lass_dp #(
		.MAX_PIECES  (MAX_PIECES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.file_size    (file_size),
		.data_byte    (data_byte),
		.m_tready     (m_tready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_tvalid),
		.piece_offset (piece_offset),
		.piece_length (piece_length),
		.piece_number (piece_number),
		.last_piece   (m_tlast)
	);

	// Pack the output transaction, zero filled to whole bytes
	assign m_tdata = M_W'({piece_number, piece_length, piece_offset});

endmodule

[rtl/lass_ctrl.sv]
// Controller state machine for the line-aligned stream splitter.
// Depends on lass_pkg (command and status structs, opcodes).
module lass_ctrl import lass_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      s_tuser,
	input  lass_sts_t sts,
	output lass_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COUNT = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_ARM   = 3'd3;
	localparam logic [2:0] ST_PEND  = 3'd4;
	localparam logic [2:0] ST_SKIP  = 3'd5;
	localparam logic [2:0] ST_FINAL = 3'd6;

	logic [2:0] state_q, state_d;
	logic       hit_q, hit_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		hit_d   = hit_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OP_START) begin
						cmd.start = 1'b1;
						state_d   = sts.trivial ? ST_FINAL : ST_COUNT;
					end else if (sts.busy) begin
						cmd.byte_in = 1'b1;
						if (sts.hit) begin
							hit_d   = 1'b1;
							state_d = ST_PEND;
						end else if (sts.eof) begin
							hit_d   = 1'b0;
							state_d = ST_PEND;
						end
					end
				end
			end
			ST_COUNT: begin
				if (sts.cnt_done) begin
					state_d = sts.n_one ? ST_FINAL : ST_DIV;
				end else begin
					cmd.cnt_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_ARM;
				end
			end
			ST_ARM: begin
				cmd.arm = 1'b1;
				state_d = ST_IDLE;
			end
			ST_PEND: begin
				if (!sts.pend_need || sts.slot_free) begin
					cmd.pend = 1'b1;
					state_d  = hit_q ? ST_SKIP : ST_FINAL;
				end
			end
			ST_SKIP: begin
				if (sts.skip_more) begin
					cmd.skip_step = 1'b1;
				end else begin
					state_d = sts.finish ? ST_FINAL : ST_IDLE;
				end
			end
			ST_FINAL: begin
				if (sts.slot_free) begin
					cmd.final_pc = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_q   <= hit_d;
		end
	end

endmodule

[rtl/lass_dp.sv]
// Datapath for the line-aligned stream splitter: config registers, file state,
// piece count search, serial divider, target tracking and the output register.
// Depends on lass_pkg (command and status structs, constants).
module lass_dp import lass_pkg::*; #(
	parameter int MAX_PIECES  = 64,
	parameter int OFFSET_BITS = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [OFFSET_BITS-1:0]   file_size,
	input  logic [7:0]               data_byte,
	input  logic                     m_tready,
	input  lass_cmd_t                cmd,
	output lass_sts_t                sts,
	output logic                     out_valid,
	output logic [OFFSET_BITS-1:0]   piece_offset,
	output logic [OFFSET_BITS-1:0]   piece_length,
	output logic [PIECE_NUM_W-1:0]   piece_number,
	output logic                     last_piece
);

	localparam int CNT_W = $clog2(MAX_PIECES + 1);
	localparam int LIM_W = (CNT_W > MAX_PIECES_W) ? CNT_W : MAX_PIECES_W;
	localparam int ACC_W = ((OFFSET_BITS > PIECE_BYTES_W) ? OFFSET_BITS : PIECE_BYTES_W)
		+ CNT_W;
	localparam int DIV_W = $clog2(OFFSET_BITS);

	logic [PIECE_BYTES_W-1:0] piece_bytes_q;
	logic [MAX_PIECES_W-1:0]  max_pieces_q;
	logic                     busy_q;
	logic                     out_valid_q;

	logic [OFFSET_BITS-1:0]   file_len_q;
	logic [OFFSET_BITS-1:0]   step_len_q;
	logic [OFFSET_BITS-1:0]   tpos_q;
	logic [OFFSET_BITS-1:0]   byte_count_q;
	logic [OFFSET_BITS-1:0]   last_bound_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         tidx_q;
	logic [CNT_W-1:0]         rem_q;
	logic [ACC_W-1:0]         acc_q;
	logic [DIV_W-1:0]         div_cnt_q;
	logic [PIECE_NUM_W-1:0]   out_count_q;
	logic [OFFSET_BITS-1:0]   out_offset_q;
	logic [OFFSET_BITS-1:0]   out_length_q;
	logic [PIECE_NUM_W-1:0]   out_number_q;
	logic                     out_last_q;

	logic [LIM_W-1:0]         mp_ext;
	logic [LIM_W-1:0]         lim_w;
	logic [CNT_W-1:0]         lim;
	logic [OFFSET_BITS-1:0]   byte_inc;
	logic [CNT_W:0]           trial;
	logic [CNT_W:0]           trial_sub;
	logic                     trial_ge;
	logic                     emit;
	logic [OFFSET_BITS-1:0]   emit_offset;
	logic [OFFSET_BITS-1:0]   emit_length;

	// Effective piece limit: zero acts as one, capped by the build limit
	assign mp_ext = LIM_W'(max_pieces_q);
	always_comb begin
		if (max_pieces_q == '0) begin
			lim_w = LIM_W'(1);
		end else if (mp_ext > LIM_W'(MAX_PIECES)) begin
			lim_w = LIM_W'(MAX_PIECES);
		end else begin
			lim_w = mp_ext;
		end
	end
	assign lim = lim_w[CNT_W-1:0];

	assign byte_inc = byte_count_q + OFFSET_BITS'(1);

	// Restoring divider, one quotient bit per cycle shifted into step_len_q
	assign trial     = {rem_q, step_len_q[OFFSET_BITS-1]};
	assign trial_ge  = (trial >= {1'b0, n_q});
	assign trial_sub = trial - {1'b0, n_q};

	assign sts.busy      = busy_q;
	assign sts.hit       = (data_byte == NEWLINE) && (byte_count_q >= tpos_q);
	assign sts.eof       = (byte_inc == file_len_q);
	assign sts.trivial   = (file_size == '0) || (piece_bytes_q == '0);
	assign sts.cnt_done  = (acc_q >= ACC_W'(file_len_q)) || (n_q >= lim);
	assign sts.n_one     = (n_q == CNT_W'(1));
	assign sts.div_done  = (div_cnt_q == DIV_W'(OFFSET_BITS - 1));
	assign sts.skip_more = (tidx_q < n_q) && (tpos_q < byte_count_q);
	assign sts.finish    = (tidx_q >= n_q) || (byte_count_q == file_len_q);
	assign sts.pend_need = (byte_count_q > last_bound_q);
	assign sts.slot_free = !out_valid_q || m_tready;

	assign emit        = (cmd.pend && sts.pend_need) || cmd.final_pc;
	assign emit_offset = cmd.final_pc ? byte_count_q : last_bound_q;
	assign emit_length = cmd.final_pc ? (file_len_q - byte_count_q)
		: (byte_count_q - last_bound_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_bytes_q <= PIECE_BYTES_RST;
			max_pieces_q  <= MAX_PIECES_RST;
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PIECE_BYTES: piece_bytes_q <= cfg_wdata[PIECE_BYTES_W-1:0];
					REG_MAX_PIECES:  max_pieces_q  <= cfg_wdata[MAX_PIECES_W-1:0];
					default: ;
				endcase
			end
			if (cmd.start || cmd.final_pc) begin
				busy_q <= 1'b0;
			end else if (cmd.arm) begin
				busy_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			file_len_q   <= file_size;
			step_len_q   <= file_size;
			byte_count_q <= '0;
			last_bound_q <= '0;
			out_count_q  <= '0;
			n_q          <= CNT_W'(1);
			acc_q        <= ACC_W'(piece_bytes_q);
			rem_q        <= '0;
			div_cnt_q    <= '0;
		end
		if (cmd.byte_in) begin
			byte_count_q <= byte_inc;
		end
		if (cmd.cnt_step) begin
			n_q   <= n_q + CNT_W'(1);
			acc_q <= acc_q + ACC_W'(piece_bytes_q);
		end
		if (cmd.div_step) begin
			rem_q      <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
			step_len_q <= {step_len_q[OFFSET_BITS-2:0], trial_ge};
			div_cnt_q  <= div_cnt_q + DIV_W'(1);
		end
		if (cmd.arm) begin
			tidx_q <= CNT_W'(1);
			tpos_q <= step_len_q;
		end
		if (cmd.skip_step) begin
			tidx_q <= tidx_q + CNT_W'(1);
			tpos_q <= tpos_q + step_len_q;
		end
		if (cmd.pend) begin
			last_bound_q <= byte_count_q;
		end
		if (emit) begin
			out_offset_q <= emit_offset;
			out_length_q <= emit_length;
			out_number_q <= out_count_q;
			out_last_q   <= cmd.final_pc;
			out_count_q  <= out_count_q + PIECE_NUM_W'(1);
		end
	end

	assign out_valid    = out_valid_q;
	assign piece_offset = out_offset_q;
	assign piece_length = out_length_q;
	assign piece_number = out_number_q;
	assign last_piece   = out_last_q;

endmodule

[rtl/lass_checker.sv]
// Port-level checks for the line-aligned stream splitter, bound to the top level.
// Depends on lass_pkg (opcodes) and line_aligned_stream_splitter.
module lass_checker import lass_pkg::*; #(
	parameter int OFFSET_BITS = 40
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                s_tuser,
	input logic [((OFFSET_BITS+15)/8)*8-1:0]   s_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((2*OFFSET_BITS+13)/8)*8-1:0] m_tdata,
	input logic                                m_tlast
);

	// Hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// Only the final piece of a file may be empty
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[2*OFFSET_BITS-1:OFFSET_BITS] != '0)
		else $error("empty piece not marked last");

	// A start always leaves the idle state, so input is held off next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_START |=> !s_tready)
		else $error("input taken right after a start transaction");

endmodule

bind line_aligned_stream_splitter lass_checker #(.OFFSET_BITS(OFFSET_BITS)) u_lass_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
